// ----- rtl/core/cpst_pkg.sv -----
`default_nettype none

package cpst_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PIPE_DEPTH = 6;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS   = 2'd2
    } cfg_index_t;

    localparam logic OP_POINT   = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/cpst_if.sv -----
`default_nettype none

interface cpst_req_if
    import cpst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;

    modport source
    (
        output valid,
        output operation,
        output first_x,
        output first_y,
        output second_x,
        output second_y,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  operation,
        input  first_x,
        input  first_y,
        input  second_x,
        input  second_y,
        output ready
    );
endinterface

interface cpst_rsp_if;
    logic valid;
    logic ready;
    logic touching;

    modport source
    (
        output valid,
        output touching,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  touching,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/cpst_mul.sv -----
`default_nettype none

module cpst_mul
    import cpst_pkg::*;
#(
    parameter int A = 2 * (COORD_BITS_DEF + 1)
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [A-1:0]   a,
    input  logic signed [A-1:0]   b,
    output logic signed [2*A-1:0] p
);
    localparam int H  = A / 2;
    localparam int G  = A - H;
    localparam int PW = 2 * A;

    logic [H-1:0]            al;
    logic [H-1:0]            bl;
    logic signed [G-1:0]     ah;
    logic signed [G-1:0]     bh;

    logic signed [2*G-1:0]   pp_hh_reg;
    logic signed [G+H:0]     pp_hl_reg;
    logic signed [G+H:0]     pp_lh_reg;
    logic [2*H-1:0]          pp_ll_reg;
    logic signed [PW-1:0]    p_reg;

    logic signed [PW-1:0]    hh_ext;
    logic signed [PW-1:0]    hl_ext;
    logic signed [PW-1:0]    lh_ext;
    logic signed [PW-1:0]    ll_ext;
    logic signed [PW-1:0]    p_next;

    assign al = a[H-1:0];
    assign bl = b[H-1:0];
    assign ah = $signed(a[A-1:H]);
    assign bh = $signed(b[A-1:H]);

    // partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_hh_reg <= ah * bh;
            pp_hl_reg <= ah * $signed({1'b0, bl});
            pp_lh_reg <= $signed({1'b0, al}) * bh;
            pp_ll_reg <= al * bl;
        end
    end

    always_comb
    begin
        hh_ext = $signed({{(PW-2*G){pp_hh_reg[2*G-1]}}, pp_hh_reg});
        hl_ext = $signed({{(PW-G-H-1){pp_hl_reg[G+H]}}, pp_hl_reg});
        lh_ext = $signed({{(PW-G-H-1){pp_lh_reg[G+H]}}, pp_lh_reg});
        ll_ext = $signed({{(PW-2*H){1'b0}}, pp_ll_reg});
        p_next = (hh_ext <<< (2*H)) + ((hl_ext + lh_ext) <<< H) + ll_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- rtl/core/circle_point_segment_touch.sv -----
// Tests each request against a configured circle (center, radius) in signed fixed
// point with 4 fraction bits: a point request reports whether the point lies within
// the radius, a segment request whether the segment crosses the circle's boundary,
// all by exact squared comparisons. The pipeline takes one request every cycle while
// the response is not stalled and returns its answers in order; the depth is set by
// the difference, product and sum stages, the two-stage wide multiplier for the
// perpendicular-distance test and the output register. A stalled response freezes
// the whole pipeline, so ready follows the output register. Write the centre and
// radius only while no request is in flight.
`default_nettype none

module circle_point_segment_touch
    import cpst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]     cfg_data,
    cpst_req_if.sink                  req,
    cpst_rsp_if.source                rsp
);
    localparam int D   = COORD_BITS + 1;
    localparam int P   = 2 * D;
    localparam int R2W = 2 * COORD_BITS - 2;
    localparam int ML  = 2 * P;

    logic signed [COORD_BITS-1:0] cx_reg;
    logic signed [COORD_BITS-1:0] cy_reg;
    logic [COORD_BITS-2:0]        r_reg;

    logic [PIPE_DEPTH-1:0]        v_reg;
    logic [PIPE_DEPTH-1:0]        v_next;
    logic                         adv;

    // stage 1: offsets
    logic                  s1_op_reg;
    logic signed [D-1:0]   s1_opx_reg, s1_opy_reg, s1_oqx_reg, s1_oqy_reg;
    logic signed [D-1:0]   s1_pqx_reg, s1_pqy_reg;
    logic signed [D-1:0]   s1_opx_next, s1_opy_next, s1_oqx_next, s1_oqy_next;
    logic signed [D-1:0]   s1_pqx_next, s1_pqy_next;
    logic signed [D-1:0]   px_ext, py_ext, qx_ext, qy_ext, cx_ext, cy_ext;

    // stage 2: products
    logic                  s2_op_reg;
    logic signed [P-1:0]   s2_sq_opx_reg, s2_sq_opy_reg, s2_sq_oqx_reg, s2_sq_oqy_reg;
    logic signed [P-1:0]   s2_ppx_reg, s2_ppy_reg, s2_qpx_reg, s2_qpy_reg;
    logic signed [P-1:0]   s2_cr1_reg, s2_cr2_reg, s2_sq_pqx_reg, s2_sq_pqy_reg;
    logic [R2W-1:0]        s2_r2_reg;

    // stage 3: sums
    logic                  s3_op_reg;
    logic signed [P-1:0]   s3_dp_reg, s3_dq_reg, s3_dotp_reg, s3_dotq_reg;
    logic signed [P-1:0]   s3_cross_reg, s3_pq2_reg;
    logic [R2W-1:0]        s3_r2_reg;
    logic signed [P-1:0]   r2_ext;

    // stages 4 and 5: flags beside the wide multipliers
    logic                  s4_op_reg, s4_point_reg, s4_far_reg, s4_near_reg, s4_acute_reg;
    logic                  s4_point_next, s4_far_next, s4_near_next, s4_acute_next;
    logic                  s5_op_reg, s5_point_reg, s5_far_reg, s5_near_reg, s5_acute_reg;
    logic signed [ML-1:0]  lhs;
    logic signed [ML-1:0]  rhs;

    logic                  touch_reg;
    logic                  touch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            r_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X: cx_reg <= $signed(cfg_data);
                CFG_CENTER_Y: cy_reg <= $signed(cfg_data);
                CFG_RADIUS:   r_reg  <= cfg_data[COORD_BITS-2:0];
                default:      ;
            endcase
        end
    end

    assign adv       = !v_reg[PIPE_DEPTH-1] || rsp.ready;
    assign req.ready = adv;
    assign v_next    = {v_reg[PIPE_DEPTH-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        px_ext = $signed({req.first_x[COORD_BITS-1], req.first_x});
        py_ext = $signed({req.first_y[COORD_BITS-1], req.first_y});
        qx_ext = $signed({req.second_x[COORD_BITS-1], req.second_x});
        qy_ext = $signed({req.second_y[COORD_BITS-1], req.second_y});
        cx_ext = $signed({cx_reg[COORD_BITS-1], cx_reg});
        cy_ext = $signed({cy_reg[COORD_BITS-1], cy_reg});
        s1_opx_next = px_ext - cx_ext;
        s1_opy_next = py_ext - cy_ext;
        s1_oqx_next = qx_ext - cx_ext;
        s1_oqy_next = qy_ext - cy_ext;
        s1_pqx_next = qx_ext - px_ext;
        s1_pqy_next = qy_ext - py_ext;
    end

    always_comb
    begin
        r2_ext        = $signed({{(P-R2W){1'b0}}, s3_r2_reg});
        s4_point_next = s3_dp_reg <= r2_ext;
        s4_far_next   = (s3_dp_reg >= r2_ext) || (s3_dq_reg >= r2_ext);
        s4_near_next  = (s3_dp_reg <= r2_ext) || (s3_dq_reg <= r2_ext);
        // both end angles strictly acute
        s4_acute_next = s3_dotp_reg[P-1]
                        && !s3_dotq_reg[P-1] && (s3_dotq_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg     <= req.operation;
            s1_opx_reg    <= s1_opx_next;
            s1_opy_reg    <= s1_opy_next;
            s1_oqx_reg    <= s1_oqx_next;
            s1_oqy_reg    <= s1_oqy_next;
            s1_pqx_reg    <= s1_pqx_next;
            s1_pqy_reg    <= s1_pqy_next;

            s2_op_reg     <= s1_op_reg;
            s2_sq_opx_reg <= s1_opx_reg * s1_opx_reg;
            s2_sq_opy_reg <= s1_opy_reg * s1_opy_reg;
            s2_sq_oqx_reg <= s1_oqx_reg * s1_oqx_reg;
            s2_sq_oqy_reg <= s1_oqy_reg * s1_oqy_reg;
            s2_ppx_reg    <= s1_opx_reg * s1_pqx_reg;
            s2_ppy_reg    <= s1_opy_reg * s1_pqy_reg;
            s2_qpx_reg    <= s1_oqx_reg * s1_pqx_reg;
            s2_qpy_reg    <= s1_oqy_reg * s1_pqy_reg;
            s2_cr1_reg    <= s1_opx_reg * s1_oqy_reg;
            s2_cr2_reg    <= s1_opy_reg * s1_oqx_reg;
            s2_sq_pqx_reg <= s1_pqx_reg * s1_pqx_reg;
            s2_sq_pqy_reg <= s1_pqy_reg * s1_pqy_reg;
            s2_r2_reg     <= r_reg * r_reg;

            s3_op_reg     <= s2_op_reg;
            s3_dp_reg     <= s2_sq_opx_reg + s2_sq_opy_reg;
            s3_dq_reg     <= s2_sq_oqx_reg + s2_sq_oqy_reg;
            s3_dotp_reg   <= s2_ppx_reg + s2_ppy_reg;
            s3_dotq_reg   <= s2_qpx_reg + s2_qpy_reg;
            s3_cross_reg  <= s2_cr1_reg - s2_cr2_reg;
            s3_pq2_reg    <= s2_sq_pqx_reg + s2_sq_pqy_reg;
            s3_r2_reg     <= s2_r2_reg;

            s4_op_reg     <= s3_op_reg;
            s4_point_reg  <= s4_point_next;
            s4_far_reg    <= s4_far_next;
            s4_near_reg   <= s4_near_next;
            s4_acute_reg  <= s4_acute_next;

            s5_op_reg     <= s4_op_reg;
            s5_point_reg  <= s4_point_reg;
            s5_far_reg    <= s4_far_reg;
            s5_near_reg   <= s4_near_reg;
            s5_acute_reg  <= s4_acute_reg;

            touch_reg     <= touch_next;
        end
    end

    // cross squared against radius squared times length squared
    cpst_mul #(
        .A (P)
    ) u_mul_lhs (
        .clk (clk),
        .en  (adv),
        .a   (s3_cross_reg),
        .b   (s3_cross_reg),
        .p   (lhs)
    );

    cpst_mul #(
        .A (P)
    ) u_mul_rhs (
        .clk (clk),
        .en  (adv),
        .a   (r2_ext),
        .b   (s3_pq2_reg),
        .p   (rhs)
    );

    always_comb
    begin
        case (s5_op_reg)
            OP_POINT:   touch_next = s5_point_reg;
            OP_SEGMENT: touch_next = s5_far_reg
                                     && (s5_acute_reg ? (lhs <= rhs) : s5_near_reg);
            default:    touch_next = 1'b0;
        endcase
    end

    assign rsp.valid    = v_reg[PIPE_DEPTH-1];
    assign rsp.touching = touch_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cpst_check.sv -----
`default_nettype none

module cpst_check
    import cpst_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic touching
);
    localparam int CW = $clog2(PIPE_DEPTH + 1) + 1;

    logic          req_acc;
    logic          rsp_acc;
    logic [CW-1:0] pending_reg;
    logic [CW-1:0] pending_next;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (req_acc && !rsp_acc)
        begin
            pending_next = pending_reg + CW'(1);
        end
        else if (!req_acc && rsp_acc)
        begin
            pending_next = pending_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // held response keeps its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(touching))
        else $error("response changed while stalled");

    // input only back-pressured by a blocked output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request refused without output stall");

    // no response without a request in flight
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != '0)
        else $error("response without pending request");

    // in-flight requests bounded by pipeline depth
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CW'(PIPE_DEPTH))
        else $error("too many requests in flight");

endmodule

bind circle_point_segment_touch cpst_check u_cpst_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .touching  (rsp.touching)
);

`default_nettype wire
